>>> hdl/adts_frame_header_parser_defines.svh
// Assertion macros shared by the checker of the ADTS header parser.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ADTS_FRAME_HEADER_PARSER_DEFINES_SVH
`define ADTS_FRAME_HEADER_PARSER_DEFINES_SVH

// Checked only while the block is out of reset.
`define AFHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define AFHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/afhp_pkg.sv
// Types, codes and constants of the ADTS frame header parser.
// Depends on nothing; imported by every module of the block.
package afhp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SKIP    = 2'd1,
    PH_STOPPED = 2'd2
  } afhp_phase_t;

  typedef enum logic [2:0] {
    ST_CLEAN     = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_SYNC  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_OVERFLOW  = 3'd5
  } afhp_status_t;

  typedef enum logic {
    KIND_DESC   = 1'b0,
    KIND_STATUS = 1'b1
  } afhp_kind_t;

  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE = 4'hF;
  localparam logic [2:0]  HDR_LAST    = 3'd6;
  localparam logic [12:0] MIN_FRAME   = 13'd7;
  localparam logic [3:0]  HL_NO_CRC   = 4'd7;
  localparam logic [3:0]  HL_CRC      = 4'd9;
  localparam logic [21:0] TOTAL_MAX   = 22'h3FFFFF;
  localparam logic [2:0]  DEFAULT_CH  = 3'd2;
  localparam logic [16:0] MIN_RATE    = 17'd8000;
  localparam int          QDEPTH      = 4;

  typedef struct packed {
    logic         has_desc;
    logic         has_stat;
    logic [23:0]  frame_start;
    logic         prot_absent;
    logic [3:0]   rate_idx;
    logic [2:0]   ch_cfg;
    logic [12:0]  frame_len;
    afhp_status_t status;
    logic [21:0]  found;
  } afhp_entry_t;

  function automatic logic [16:0] rate_hz(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      default: r = 17'd48000;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/afhp_queue.sv
// Short request queue between the parser front and the result back end.
// Depends on afhp_pkg for the entry type and the depth.
module afhp_queue import afhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        enq,
  input  afhp_entry_t enq_data,
  output logic        q_full,
  input  logic        deq,
  output afhp_entry_t head,
  output logic        q_empty
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  afhp_entry_t   mem_r [QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_enq, do_deq;

  assign q_full  = (cnt_r == CW'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_enq  = enq && !q_full;
  assign do_deq  = deq && !q_empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_enq ? PW'((32'(wr_r) + 1) % QDEPTH) : wr_r;
    rd_nxt  = do_deq ? PW'((32'(rd_r) + 1) % QDEPTH) : rd_r;
    cnt_nxt = cnt_r + CW'(do_enq) - CW'(do_deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem_r[wr_r] <= enq_data;
    end
  end

endmodule

>>> hdl/afhp_front.sv
// Byte parser: tracks the header and skip phases and classifies each byte.
// Depends on afhp_pkg; feeds requests into afhp_queue.
module afhp_front import afhp_pkg::*; #(
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        enq,
  output afhp_entry_t enq_data
);

  afhp_phase_t            phase_r, phase_step, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, fs_r, fs_nxt, off_inc;
  logic [39:0]            hdr_r, hdr_nxt;
  logic                   sync_r, sync_nxt;
  logic [12:0]            left_r, left_nxt, left_dec;
  logic [21:0]            total_r, total_nxt, total_step;
  afhp_status_t           reason_r, reason_nxt, reason_step, status;
  logic [2:0]             idx_r, idx_nxt, idx_step;

  logic        ovf, live, hdr_end, len_bad, bad_sync, bad_len, short_frame;
  logic        start_skip, skip_done, emit;
  logic [12:0] fl;
  logic [3:0]  hl;

  assign fl       = {hdr_r[17:16], hdr_r[15:8], hdr_r[7:5]};
  assign hl       = hdr_r[32] ? HL_NO_CRC : HL_CRC;
  assign ovf      = &off_r;
  assign live     = (phase_r != PH_STOPPED) && !ovf;
  assign off_inc  = off_r + 1'b1;
  assign left_dec = left_r - 13'(left_r != '0);

  assign hdr_end     = live && (phase_r == PH_HEADER) && (idx_r == HDR_LAST);
  assign len_bad     = fl < 13'(hl);
  assign bad_sync    = hdr_end && !sync_r;
  assign bad_len     = hdr_end && sync_r && len_bad;
  assign short_frame = hdr_end && sync_r && !len_bad && (fl == MIN_FRAME);
  assign start_skip  = hdr_end && sync_r && !len_bad && (fl != MIN_FRAME);
  assign skip_done   = live && (phase_r == PH_SKIP) && (left_dec == '0);
  assign emit        = short_frame || skip_done;

  always_comb begin
    phase_step = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (ovf || bad_sync || bad_len) begin
          phase_step = PH_STOPPED;
        end else if (start_skip) begin
          phase_step = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (ovf) begin
          phase_step = PH_STOPPED;
        end else if (skip_done) begin
          phase_step = PH_HEADER;
        end
      end
      default: phase_step = phase_r;
    endcase
    phase_nxt = phase_r;
    if (acc) begin
      phase_nxt = final_byte ? PH_HEADER : phase_step;
    end
  end

  always_comb begin
    off_nxt     = off_r;
    fs_nxt      = fs_r;
    hdr_nxt     = hdr_r;
    sync_nxt    = sync_r;
    left_nxt    = left_r;
    total_nxt   = total_r;
    reason_nxt  = reason_r;
    idx_nxt     = idx_r;
    idx_step    = idx_r;
    total_step  = total_r;
    reason_step = reason_r;
    status      = ST_CLEAN;
    enq         = 1'b0;

    if (live) begin
      if (phase_r == PH_HEADER) begin
        if (idx_r == 3'd0) begin
          sync_nxt = (data_byte == SYNC_BYTE);
        end else if (idx_r != HDR_LAST) begin
          if ((idx_r == 3'd1) && (data_byte[7:4] != SYNC_NIBBLE)) begin
            sync_nxt = 1'b0;
          end
          hdr_nxt = {hdr_r[31:0], data_byte};
        end
        idx_step = (idx_r == HDR_LAST) ? 3'd0 : idx_r + 3'd1;
        if (start_skip) begin
          left_nxt = fl - MIN_FRAME;
        end
      end else begin
        left_nxt = left_dec;
        if (skip_done) begin
          idx_step = 3'd0;
        end
      end
    end
    if (emit && (total_r != TOTAL_MAX)) begin
      total_step = total_r + 22'd1;
    end
    if (live) begin
      off_nxt = off_inc;
    end
    if (emit) begin
      fs_nxt = off_inc;
    end
    if (phase_r != PH_STOPPED) begin
      if (ovf) begin
        reason_step = ST_OVERFLOW;
      end else if (bad_sync) begin
        reason_step = ST_BAD_SYNC;
      end else if (bad_len) begin
        reason_step = ST_BAD_LEN;
      end
    end
    if (phase_step == PH_STOPPED) begin
      status = reason_step;
    end else if (phase_step == PH_SKIP) begin
      status = ST_TRUNCATED;
    end else if (idx_step != 3'd0) begin
      status = ST_SHORT;
    end
    idx_nxt    = idx_step;
    total_nxt  = total_step;
    reason_nxt = reason_step;

    if (!acc) begin
      off_nxt    = off_r;
      fs_nxt     = fs_r;
      hdr_nxt    = hdr_r;
      sync_nxt   = sync_r;
      left_nxt   = left_r;
      total_nxt  = total_r;
      reason_nxt = reason_r;
      idx_nxt    = idx_r;
    end else begin
      enq = emit || final_byte;
      if (final_byte) begin
        off_nxt    = '0;
        fs_nxt     = '0;
        sync_nxt   = 1'b1;
        left_nxt   = '0;
        total_nxt  = '0;
        reason_nxt = ST_CLEAN;
        idx_nxt    = '0;
      end
    end

    enq_data.has_desc    = emit;
    enq_data.has_stat    = final_byte;
    enq_data.frame_start = 24'(32'(fs_r));
    enq_data.prot_absent = hdr_r[32];
    enq_data.rate_idx    = hdr_r[29:26];
    enq_data.ch_cfg      = {hdr_r[24], hdr_r[23:22]};
    enq_data.frame_len   = fl;
    enq_data.status      = status;
    enq_data.found       = total_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      fs_r     <= '0;
      sync_r   <= 1'b1;
      left_r   <= '0;
      total_r  <= '0;
      reason_r <= ST_CLEAN;
      idx_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      fs_r     <= fs_nxt;
      sync_r   <= sync_nxt;
      left_r   <= left_nxt;
      total_r  <= total_nxt;
      reason_r <= reason_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

>>> hdl/afhp_back.sv
// Result back end: formats queued requests and sends one or two results each.
// Depends on afhp_pkg for the entry type and the rate table.
module afhp_back import afhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  afhp_entry_t head,
  input  logic        q_empty,
  output logic        deq,
  input  logic        pop,
  output logic        empty,
  output logic        out_item_kind,
  output logic [23:0] out_payload_offset,
  output logic [12:0] out_payload_size,
  output logic [16:0] out_sample_rate_hz,
  output logic [2:0]  out_channels,
  output logic        out_crc_present,
  output logic [2:0]  out_end_status,
  output logic [21:0] out_frames_found,
  output logic        out_last_of_run
);

  logic       sub_r, sub_nxt;
  logic       show_desc, take;
  logic [3:0] hl;

  assign empty     = q_empty;
  assign take      = pop && !q_empty;
  assign show_desc = head.has_desc && !sub_r;
  assign hl        = head.prot_absent ? HL_NO_CRC : HL_CRC;
  assign deq       = take && !(show_desc && head.has_stat);

  always_comb begin
    sub_nxt = sub_r;
    if (take) begin
      sub_nxt = show_desc && head.has_stat;
    end
  end

  always_comb begin
    out_item_kind      = KIND_STATUS;
    out_payload_offset = '0;
    out_payload_size   = '0;
    out_sample_rate_hz = '0;
    out_channels       = '0;
    out_crc_present    = 1'b0;
    out_end_status     = head.status;
    out_frames_found   = head.found;
    out_last_of_run    = 1'b1;
    if (show_desc) begin
      out_item_kind      = KIND_DESC;
      out_payload_offset = head.frame_start + 24'(hl);
      out_payload_size   = head.frame_len - 13'(hl);
      out_sample_rate_hz = rate_hz(head.rate_idx);
      out_channels       = (head.ch_cfg == '0) ? DEFAULT_CH : head.ch_cfg;
      out_crc_present    = !head.prot_absent;
      out_end_status     = ST_CLEAN;
      out_frames_found   = '0;
      out_last_of_run    = !head.has_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

>>> hdl/adts_frame_header_parser.sv
// ADTS frame header parser, top level: parser front, request queue, result back end.
// Depends on afhp_pkg, afhp_front, afhp_queue and afhp_back.
//
// The parser takes one byte per clock while full is low; full rises only when the
// four-entry request queue between the parser and the result side is taken up. A
// byte that finishes a frame or ends the buffer leaves a request that shows as a
// result once the requests ahead of it are popped. The result side sends one result
// per cycle while pop is high, so a final byte that also closes a frame gives two
// results; queue depth and pop rate set how long a burst runs at one byte per cycle.
module adts_frame_header_parser import afhp_pkg::*; #(
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_item_kind,
  output logic [23:0] out_payload_offset,
  output logic [12:0] out_payload_size,
  output logic [16:0] out_sample_rate_hz,
  output logic [2:0]  out_channels,
  output logic        out_crc_present,
  output logic [2:0]  out_end_status,
  output logic [21:0] out_frames_found,
  output logic        out_last_of_run
);

  afhp_entry_t enq_data, head;
  logic        enq, deq, q_full, q_empty, acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  afhp_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .final_byte(in_final_byte),
    .enq       (enq),
    .enq_data  (enq_data)
  );

  afhp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .enq_data(enq_data),
    .q_full  (q_full),
    .deq     (deq),
    .head    (head),
    .q_empty (q_empty)
  );

  afhp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_empty           (q_empty),
    .deq               (deq),
    .pop               (pop),
    .empty             (empty),
    .out_item_kind     (out_item_kind),
    .out_payload_offset(out_payload_offset),
    .out_payload_size  (out_payload_size),
    .out_sample_rate_hz(out_sample_rate_hz),
    .out_channels      (out_channels),
    .out_crc_present   (out_crc_present),
    .out_end_status    (out_end_status),
    .out_frames_found  (out_frames_found),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

>>> hdl/afhp_checker.sv
// Port-level checker of the ADTS frame header parser and its bind to the top level.
// Depends on afhp_pkg and adts_frame_header_parser_defines.svh.
`include "adts_frame_header_parser_defines.svh"

module afhp_checker import afhp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic [7:0]  in_data_byte,
  input logic        in_final_byte,
  input logic        empty,
  input logic        pop,
  input logic        out_item_kind,
  input logic [23:0] out_payload_offset,
  input logic [12:0] out_payload_size,
  input logic [16:0] out_sample_rate_hz,
  input logic [2:0]  out_channels,
  input logic        out_crc_present,
  input logic [2:0]  out_end_status,
  input logic [21:0] out_frames_found,
  input logic        out_last_of_run
);

  `AFHP_ASSERT(a_desc_no_status, (!empty && out_item_kind == KIND_DESC) |-> (out_end_status == ST_CLEAN && out_frames_found == '0), "descriptor carries status fields")
  `AFHP_ASSERT(a_desc_fields, (!empty && out_item_kind == KIND_DESC) |-> (out_channels != '0 && out_sample_rate_hz >= MIN_RATE), "descriptor with bad channels or rate")
  `AFHP_ASSERT(a_status_fields, (!empty && out_item_kind == KIND_STATUS) |-> (out_last_of_run && out_payload_offset == '0 && out_payload_size == '0 && out_channels == '0 && !out_crc_present), "status request is malformed")
  `AFHP_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(out_item_kind) && $stable(out_payload_offset) && $stable(out_end_status)), "waiting result changed")
  `AFHP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (empty && !full), "queue not cleared by reset")

endmodule

bind adts_frame_header_parser afhp_checker u_afhp_checker (.*);
